[src/gcpc_pkg.sv]
// ============================================================================
// gcpc_pkg: shared types and constants for the grid cell prefix code packer
// Transaction structs for both sides, the prefix code tables and queue sizing.
// ============================================================================
package gcpc_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] BUDGET_RESET = 16'd64;
    localparam logic [15:0] CELLS_MAX    = 16'hffff;
    localparam logic [3:0]  BYTE_BITS    = 4'd8;

    localparam logic [7:0] CODE_BITS [4] = '{8'h00, 8'h02, 8'h0c, 8'h0e};
    localparam logic [3:0] CODE_LEN  [4] = '{4'd1, 4'd2, 4'd4, 4'd4};

    typedef struct packed {
        logic [1:0] cell_code;
        logic       run_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_end;
        logic [15:0] cells_done;
    } out_item_t;

    typedef struct packed {
        out_item_t first;
        out_item_t second;
        logic      two;
    } pair_t;

endpackage

[src/gcpc_front.sv]
// ============================================================================
// gcpc_front: cell encoder and run state
// Accepts cells, appends prefix codes, forms bytes and end transactions.
// ============================================================================
module gcpc_front
    import gcpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    item,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    output logic        q_push,
    output pair_t       q_entry
);

    logic [10:0] acc_reg, acc_next;
    logic [3:0]  pend_reg, pend_next;
    logic [15:0] bw_reg, bw_next;
    logic [15:0] cells_reg, cells_next;
    logic        bf_reg, bf_next;
    logic [15:0] budget_reg, budget_next;

    logic        ok;
    logic [3:0]  len;
    logic [10:0] acc_w;
    logic [3:0]  pend_w;
    logic [15:0] bw_w;
    logic        byte_hit;
    logic [7:0]  byte_val;
    out_item_t   byte_res;
    out_item_t   end_res;

    always_comb
    begin
        budget_next = cfg_write ? cfg_data : budget_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        bw_next     = bw_reg;
        cells_next  = cells_reg;
        bf_next     = bf_reg;
        q_push      = 1'b0;
        q_entry     = '0;
        byte_res    = '0;
        end_res     = '0;

        ok       = !bf_reg && (bw_reg < budget_reg);
        len      = CODE_LEN[item.cell_code];
        acc_w    = (acc_reg << len) | 11'(CODE_BITS[item.cell_code]);
        pend_w   = pend_reg + len;
        bw_w     = bw_reg;
        byte_hit = 1'b0;
        byte_val = '0;

        if (accept)
        begin
            if (ok)
            begin
                if (pend_w >= BYTE_BITS)
                begin
                    pend_w   = pend_w - BYTE_BITS;
                    byte_val = 8'(acc_w >> pend_w);
                    byte_hit = 1'b1;
                    bw_w     = bw_reg + 16'd1;
                    acc_w    = acc_w & ((11'd1 << pend_w) - 11'd1);
                end
                acc_next  = acc_w;
                pend_next = pend_w;
                bw_next   = bw_w;
                if (bw_w < budget_reg)
                begin
                    if (cells_reg != CELLS_MAX)
                    begin
                        cells_next = cells_reg + 16'd1;
                    end
                end
                else
                begin
                    bf_next = 1'b1;
                end
            end
            else
            begin
                bf_next = 1'b1;
            end

            byte_res.out_byte   = byte_val;
            byte_res.byte_valid = 1'b1;

            end_res.run_end    = 1'b1;
            end_res.cells_done = cells_next;
            if ((pend_next != 4'd0) && !bf_next && (bw_next < budget_reg))
            begin
                end_res.out_byte   = 8'(acc_next << (BYTE_BITS - pend_next));
                end_res.byte_valid = 1'b1;
            end

            if (byte_hit)
            begin
                q_push        = 1'b1;
                q_entry.first = byte_res;
                if (item.run_last)
                begin
                    q_entry.second = end_res;
                    q_entry.two    = 1'b1;
                end
            end
            else if (item.run_last)
            begin
                q_push        = 1'b1;
                q_entry.first = end_res;
            end

            if (item.run_last)
            begin
                acc_next   = '0;
                pend_next  = '0;
                bw_next    = '0;
                cells_next = '0;
                bf_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pend_reg   <= '0;
            bw_reg     <= '0;
            cells_reg  <= '0;
            bf_reg     <= 1'b0;
            budget_reg <= BUDGET_RESET;
        end
        else
        begin
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            bw_reg     <= bw_next;
            cells_reg  <= cells_next;
            bf_reg     <= bf_next;
            budget_reg <= budget_next;
        end
    end

endmodule

[src/gcpc_queue.sv]
// ============================================================================
// gcpc_queue: short queue between encoder and output stage
// Holds result pairs so each side can stall on its own.
// ============================================================================
module gcpc_queue
    import gcpc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  pair_t wr_data,
    input  logic  rd_en,
    output pair_t rd_data,
    output logic  q_full,
    output logic  q_empty
);

    pair_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/gcpc_back.sv]
// ============================================================================
// gcpc_back: output stage
// Holds the head pair and presents its transactions one at a time.
// ============================================================================
module gcpc_back
    import gcpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  pair_t     q_head,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    pair_t cur_reg, cur_next;
    logic  valid_reg, valid_next;
    logic  idx_reg, idx_next;
    logic  taken;
    logic  done;

    assign empty  = !valid_reg;
    assign result = idx_reg ? cur_reg.second : cur_reg.first;

    always_comb
    begin
        taken      = valid_reg && pop;
        done       = taken && (idx_reg || !cur_reg.two);
        q_pop      = !q_empty && (!valid_reg || done);
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (taken && !done)
        begin
            idx_next = 1'b1;
        end
        if (!valid_reg || done)
        begin
            // advance to the next pair, or drop to empty
            idx_next   = 1'b0;
            valid_next = q_pop;
            if (q_pop)
            begin
                cur_next = q_head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

[src/grid_cell_prefix_code_packer.sv]
// ============================================================================
// grid_cell_prefix_code_packer: prefix code packer for occupancy cells
// Encodes 2-bit cells into bytes under a byte budget, one cell per cycle while the queue is not full.
// ============================================================================
// A result passes through the pair queue and then the output stage register.
// One cell per cycle while the queue is not full; a cell that yields a byte and ends a
// run puts two transactions out, one after the other from the output stage.
// Full rises when the four-entry pair queue is full.
// Reset: run state cleared, budget set to 64, queue and output empty.
module grid_cell_prefix_code_packer
    import gcpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic  accept;
    logic  q_push;
    pair_t q_entry;
    logic  q_pop;
    pair_t q_head;
    logic  q_empty;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    gcpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    gcpc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_full  (full),
        .q_empty (q_empty)
    );

    gcpc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

[src/gcpc_checker.sv]
// ============================================================================
// gcpc_checker: port-level checks for the prefix code packer
// Watches result transactions on the top level ports.
// ============================================================================
module gcpc_checker
    import gcpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.byte_valid) |-> result.run_end)
        else $error("bare marker without run end");

    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.byte_valid) |-> (result.out_byte == 8'h00))
        else $error("bare marker carries a byte");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.run_end) |-> (result.cells_done == 16'd0))
        else $error("cell count outside run end");

endmodule

bind grid_cell_prefix_code_packer gcpc_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
